// File: rtl/next_lexicographic_permutation_top_macros.svh
// Assertion macros used by the permutation engine controller.
// Each macro expects signals named clock and reset in the including scope.
`ifndef NEXT_LEXICOGRAPHIC_PERMUTATION_TOP_MACROS_SVH
`define NEXT_LEXICOGRAPHIC_PERMUTATION_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NLP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NLP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/nlp_pkg.sv
// Shared types and constants for the permutation engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package nlp_pkg;

   localparam int POS_W  = 4;
   localparam int CITY_W = 5;
   localparam int SIZE_W = 5;

   localparam logic [SIZE_W-1:0] SIZE_RESET     = 5'd16;
   localparam logic              CSR_SIZE_INDEX = 1'b0;

   typedef enum logic [3:0] {
      OP_HOLD,
      OP_RESTART,
      OP_SCAN_START,
      OP_SCAN_STEP,
      OP_SUCC_START,
      OP_SUCC_STEP,
      OP_SWAP_PIV,
      OP_SWAP_SUCC,
      OP_REV_LOAD,
      OP_REV_FIRST,
      OP_REV_SECOND,
      OP_EMIT_START,
      OP_EMIT_STEP
   } nlp_op_type;

   typedef struct packed {
      nlp_op_type op;
      logic       wrap;
      logic       load_out;
   } nlp_cmd_type;

   typedef struct packed {
      logic less;
      logic succ_hit;
      logic piv_zero;
      logic lo_lt_hi;
      logic is_last;
      logic out_free;
   } nlp_status_type;

endpackage

// File: rtl/nlp_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// Self-contained; no package dependency.
module nlp_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// File: rtl/nlp_ctrl.sv
// Sequencing state machine for the permutation engine.
// Depends on nlp_pkg and the assertion macro header.
`include "next_lexicographic_permutation_top_macros.svh"

module nlp_ctrl
   import nlp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic           restart,
   input  nlp_status_type status,
   output nlp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SUCC,
      ST_SWAP,
      ST_REV_LOAD,
      ST_REV,
      ST_REV_SECOND,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_HOLD;
      cmd.wrap     = 1'b0;
      cmd.load_out = 1'b0;
      req_tready   = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (restart) begin
                  cmd.op   = OP_RESTART;
                  state_in = ST_EMIT;
               end else begin
                  cmd.op   = OP_SCAN_START;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (status.less) begin
               cmd.op   = OP_SUCC_START;
               state_in = ST_SUCC;
            end else if (status.piv_zero) begin
               // No ascent anywhere: the permutation was descending.
               cmd.op   = OP_RESTART;
               cmd.wrap = 1'b1;
               state_in = ST_EMIT;
            end else begin
               cmd.op = OP_SCAN_STEP;
            end
         end
         ST_SUCC: begin
            if (status.succ_hit) begin
               cmd.op   = OP_SWAP_PIV;
               state_in = ST_SWAP;
            end else begin
               cmd.op = OP_SUCC_STEP;
            end
         end
         ST_SWAP: begin
            cmd.op   = OP_SWAP_SUCC;
            state_in = ST_REV_LOAD;
         end
         ST_REV_LOAD: begin
            cmd.op   = OP_REV_LOAD;
            state_in = ST_REV;
         end
         ST_REV: begin
            if (status.lo_lt_hi) begin
               cmd.op   = OP_REV_FIRST;
               state_in = ST_REV_SECOND;
            end else begin
               cmd.op   = OP_EMIT_START;
               state_in = ST_EMIT;
            end
         end
         ST_REV_SECOND: begin
            cmd.op   = OP_REV_SECOND;
            state_in = ST_REV;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.op       = OP_EMIT_STEP;
               cmd.load_out = 1'b1;
               if (status.is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `NLP_ASSERT_NOW(a_load_needs_slot, cmd.load_out, status.out_free, "entry loaded into a busy slot")
   `NLP_ASSERT_NEXT(a_restart_goes_emit, req_tvalid && req_tready && restart, state_ff == ST_EMIT, "restart did not start streaming")
   `NLP_ASSERT_NOW(a_idle_after_last, (state_ff == ST_IDLE) && ($past(state_ff) == ST_EMIT) && !$past(reset), $past(status.is_last && status.out_free), "stream ended before the last entry")

endmodule

// File: rtl/nlp_dp.sv
// Datapath of the permutation engine: permutation store, scan pointers and the
// result register. Depends on nlp_pkg and nlp_ram.
module nlp_dp
   import nlp_pkg::*;
#(
   parameter int MAX_CITIES = 16,
   localparam int IW = $clog2(MAX_CITIES),
   localparam int VW = $clog2(MAX_CITIES + 1)
) (
   input  logic           clock,
   input  logic           reset,
   input  nlp_cmd_type    cmd,
   input  logic           cfg_clear,
   input  logic [IW-1:0]  last_idx,
   output nlp_status_type status,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [15:0]    rsp_tdata,
   output logic           rsp_tlast,
   output logic           rsp_tuser
);

   logic [IW-1:0]         ptr_a_ff, ptr_a_in;
   logic [IW-1:0]         ptr_b_ff, ptr_b_in;
   logic [VW-1:0]         piv_val_ff, piv_val_in;
   logic [VW-1:0]         temp_ff, temp_in;
   logic                  wrapped_ff, wrapped_in;
   logic [MAX_CITIES-1:0] valid_ff, valid_in;
   logic                  vld_a_ff, vld_a_in;
   logic                  vld_b_ff, vld_b_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]      rsp_pos_ff, rsp_pos_in;
   logic [CITY_W-1:0]     rsp_city_ff, rsp_city_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_wrap_ff, rsp_wrap_in;

   logic                  clear;
   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   logic [VW-1:0]         wr_data;
   logic [VW-1:0]         ram_a, ram_b;
   logic [VW-1:0]         rd_a, rd_b;
   logic [31:0]           pos_wide;
   logic [31:0]           city_wide;

   nlp_ram #(
      .WIDTH (VW),
      .DEPTH (MAX_CITIES)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (ptr_a_in),
      .rd_addr_b (ptr_b_in),
      .rd_data_a (ram_a),
      .rd_data_b (ram_b)
   );

   // An entry never written since the last clear holds its ascending value.
   assign rd_a = vld_a_ff ? ram_a : VW'(ptr_a_ff) + VW'(1);
   assign rd_b = vld_b_ff ? ram_b : VW'(ptr_b_ff) + VW'(1);

   assign status.less     = (rd_a < rd_b);
   assign status.succ_hit = (rd_b > piv_val_ff) || (ptr_b_ff == ptr_a_ff + IW'(1));
   assign status.piv_zero = (ptr_a_ff == '0);
   assign status.lo_lt_hi = (ptr_a_ff < ptr_b_ff);
   assign status.is_last  = (ptr_a_ff == last_idx);
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      ptr_a_in   = ptr_a_ff;
      ptr_b_in   = ptr_b_ff;
      piv_val_in = piv_val_ff;
      temp_in    = temp_ff;
      wrapped_in = wrapped_ff;
      clear      = cfg_clear;
      wr_en      = 1'b0;
      wr_addr    = ptr_a_ff;
      wr_data    = rd_b;
      case (cmd.op)
         OP_RESTART: begin
            clear      = 1'b1;
            ptr_a_in   = '0;
            wrapped_in = cmd.wrap;
         end
         OP_SCAN_START: begin
            ptr_a_in = last_idx - IW'(1);
            ptr_b_in = last_idx;
         end
         OP_SCAN_STEP: begin
            ptr_a_in = ptr_a_ff - IW'(1);
            ptr_b_in = ptr_b_ff - IW'(1);
         end
         OP_SUCC_START: begin
            piv_val_in = rd_a;
            ptr_b_in   = last_idx;
         end
         OP_SUCC_STEP: begin
            ptr_b_in = ptr_b_ff - IW'(1);
         end
         OP_SWAP_PIV: begin
            wr_en   = 1'b1;
            wr_addr = ptr_a_ff;
            wr_data = rd_b;
         end
         OP_SWAP_SUCC: begin
            wr_en   = 1'b1;
            wr_addr = ptr_b_ff;
            wr_data = piv_val_ff;
         end
         OP_REV_LOAD: begin
            ptr_a_in = ptr_a_ff + IW'(1);
            ptr_b_in = last_idx;
         end
         OP_REV_FIRST: begin
            wr_en   = 1'b1;
            wr_addr = ptr_a_ff;
            wr_data = rd_b;
            temp_in = rd_a;
         end
         OP_REV_SECOND: begin
            wr_en    = 1'b1;
            wr_addr  = ptr_b_ff;
            wr_data  = temp_ff;
            ptr_a_in = ptr_a_ff + IW'(1);
            ptr_b_in = ptr_b_ff - IW'(1);
         end
         OP_EMIT_START: begin
            ptr_a_in   = '0;
            wrapped_in = cmd.wrap;
         end
         OP_EMIT_STEP: begin
            ptr_a_in = ptr_a_ff + IW'(1);
         end
         default: begin
         end
      endcase
   end

   // Valid bits follow the RAM's read-old timing so both agree on stale reads.
   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      vld_a_in = !clear && valid_ff[ptr_a_in];
      vld_b_in = !clear && valid_ff[ptr_b_in];
   end

   assign pos_wide  = 32'(ptr_a_ff);
   assign city_wide = 32'(rd_a);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_city_in  = rsp_city_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_wrap_in  = rsp_wrap_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = pos_wide[POS_W-1:0];
         rsp_city_in  = city_wide[CITY_W-1:0];
         rsp_last_in  = status.is_last;
         rsp_wrap_in  = wrapped_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_a_ff     <= '0;
         ptr_b_ff     <= '0;
         wrapped_ff   <= 1'b0;
         valid_ff     <= '0;
         vld_a_ff     <= 1'b0;
         vld_b_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_a_ff     <= ptr_a_in;
         ptr_b_ff     <= ptr_b_in;
         wrapped_ff   <= wrapped_in;
         valid_ff     <= valid_in;
         vld_a_ff     <= vld_a_in;
         vld_b_ff     <= vld_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      piv_val_ff  <= piv_val_in;
      temp_ff     <= temp_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_city_ff <= rsp_city_in;
      rsp_last_ff <= rsp_last_in;
      rsp_wrap_ff <= rsp_wrap_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_city_ff, rsp_pos_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_wrap_ff;

endmodule

// File: rtl/next_lexicographic_permutation_top.sv
// Sequence: a restart request goes straight to streaming the ascending order; an advance
// runs the pivot scan, then the successor scan, swaps pivot and successor, reverses the
// suffix pair by pair, then streams n entries, one per cycle while the result channel is ready.
// Requests: one at a time; a new one is taken only after the last entry of the previous
// one has been loaded for output. Reset is synchronous and active high; the store reads
// as ascending at once through per-entry valid bits, no clearing pass.

// Top level of the next-permutation engine: configuration register and wiring.
// Depends on nlp_pkg, nlp_ctrl, nlp_dp and nlp_ram.
module next_lexicographic_permutation_top
   import nlp_pkg::*;
#(
   parameter int MAX_CITIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] restart, [7:1] zero
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [3:0] position, [8:4] city, [15:9] zero
   output logic        rsp_tlast,   // last_entry
   output logic        rsp_tuser    // wrapped
);

   localparam int IW = $clog2(MAX_CITIES);

   // Turns a size register value into the index of the last active entry,
   // clamping the city count into the range two to MAX_CITIES.
   function automatic logic [IW-1:0] last_of(logic [SIZE_W-1:0] value);
      int count;
      count = int'(value);
      if (count < 2) begin
         count = 2;
      end
      if (count > MAX_CITIES) begin
         count = MAX_CITIES;
      end
      return IW'(count - 1);
   endfunction

   logic [SIZE_W-1:0] size_ff;
   logic [IW-1:0]     last_idx_ff;
   logic              csr_write;
   nlp_cmd_type       cmd;
   nlp_status_type    status;

   // Every write to the size register also returns the permutation to
   // ascending order, so the store always holds a permutation of 1..n.
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == CSR_SIZE_INDEX);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_SIZE_INDEX) ?
                       {{(32 - SIZE_W){1'b0}}, size_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff     <= SIZE_RESET;
         last_idx_ff <= last_of(SIZE_RESET);
      end else if (csr_write) begin
         size_ff     <= csr_pwdata[SIZE_W-1:0];
         last_idx_ff <= last_of(csr_pwdata[SIZE_W-1:0]);
      end
   end

   nlp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .restart    (req_tdata[0]),
      .status     (status),
      .cmd        (cmd)
   );

   nlp_dp #(
      .MAX_CITIES (MAX_CITIES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg_clear  (csr_write),
      .last_idx   (last_idx_ff),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for next_lexicographic_permutation_top: drives restart and advance
// requests and size writes, and predicts every streamed entry. Depends on nlp_pkg and the RTL.
module testbench
   import nlp_pkg::*;
();

   localparam int MAX_CITIES = 16;
   localparam int CLOCK_HALF = 10;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_REQUESTS = 420;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [2:0] SIZE_ADDR = {CSR_SIZE_INDEX, 2'b00};

   // Request kinds carried in the restart bit.
   localparam logic RESTART = 1'b1;
   localparam logic ADVANCE = 1'b0;

   // One streamed permutation entry, as the result channel carries it.
   typedef struct packed {
      logic [POS_W-1:0]  position;
      logic [CITY_W-1:0] city;
      logic              last_entry;
      logic              wrapped;
   } perm_entry_type;

   // Tracks the permutation the block should hold and the entries it still owes.
   class permutation_tracker_type;
      logic [CITY_W-1:0] order [MAX_CITIES];
      logic [SIZE_W-1:0] size_reg;
      perm_entry_type    owed_entries [$];
      int                failures;
      int                requests;
      int                entries;
      int                wraps;

      function new();
         size_reg = SIZE_RESET;
         make_ascending();
      endfunction

      function void make_ascending();
         for (int i = 0; i < MAX_CITIES; i++) begin
            order[i] = CITY_W'(i + 1);
         end
      endfunction

      // The size register is clamped into the range the store can hold.
      function int city_count();
         if (size_reg < 2) begin
            return 2;
         end
         if (size_reg > MAX_CITIES) begin
            return MAX_CITIES;
         end
         return int'(size_reg);
      endfunction

      // Steps to the next permutation; returns 1 when the descending order wraps around.
      function bit advance_order(int n);
         int piv;
         int succ;
         int lo;
         int hi;
         logic [CITY_W-1:0] held;
         piv = n - 2;
         while (piv >= 0 && order[piv] >= order[piv + 1]) begin
            piv--;
         end
         if (piv < 0) begin
            make_ascending();
            return 1'b1;
         end
         succ = n - 1;
         while (succ > piv + 1 && order[succ] <= order[piv]) begin
            succ--;
         end
         held = order[piv];
         order[piv] = order[succ];
         order[succ] = held;
         lo = piv + 1;
         hi = n - 1;
         while (lo < hi) begin
            held = order[lo];
            order[lo] = order[hi];
            order[hi] = held;
            lo++;
            hi--;
         end
         return 1'b0;
      endfunction

      // Any size write also puts the store back to ascending order.
      function void write_size(logic [SIZE_W-1:0] value);
         size_reg = value;
         make_ascending();
      endfunction

      function void note_request(logic restart);
         int n;
         bit wrapped;
         perm_entry_type e;
         n = city_count();
         wrapped = 1'b0;
         requests++;
         if (restart == RESTART) begin
            make_ascending();
         end else begin
            wrapped = advance_order(n);
         end
         if (wrapped) begin
            wraps++;
         end
         for (int i = 0; i < n; i++) begin
            e.position = POS_W'(i);
            e.city = order[i];
            e.last_entry = (i == n - 1);
            e.wrapped = wrapped;
            owed_entries.push_back(e);
         end
      endfunction

      function void report(string field, int exp_value, int act_value);
         failures++;
         if (failures <= 40) begin
            $error("entry %0d: %s expected %0d, got %0d", entries, field, exp_value, act_value);
         end
      endfunction

      function void check_entry(logic [POS_W-1:0] position, logic [CITY_W-1:0] city,
                                logic last_entry, logic wrapped);
         perm_entry_type e;
         if (owed_entries.size() == 0) begin
            failures++;
            if (failures <= 40) begin
               $error("entry with position %0d city %0d arrived with none expected",
                      position, city);
            end
            return;
         end
         e = owed_entries.pop_front();
         if (position !== e.position) report("position", e.position, position);
         if (city !== e.city) report("city", e.city, city);
         if (last_entry !== e.last_entry) report("last_entry", e.last_entry, last_entry);
         if (wrapped !== e.wrapped) report("wrapped", e.wrapped, wrapped);
         entries++;
      endfunction

      function int pending();
         return owed_entries.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [0] restart, [7:1] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [3:0] position, [8:4] city, [15:9] zero
   logic        rsp_tlast;        // last_entry
   logic        rsp_tuser;        // wrapped

   // While set, neither side inserts idle cycles.
   bit quiet_run = 1'b0;
   int cycle_count = 0;
   int size_writes = 0;
   permutation_tracker_type tracker = new();

   next_lexicographic_permutation_top #(
      .MAX_CITIES(MAX_CITIES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // The result side stalls at random, with a probability of 7 percent, unless a quiet stretch is running.
   always @(posedge clock) begin
      rsp_tready <= quiet_run || ($urandom_range(0, 99) >= 7);
   end

   // All handshakes are observed at the clock edge, where every driven input is stable,
   // so the prediction never depends on the order of events inside a time step.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == SIZE_ADDR) begin
            tracker.write_size(csr_pwdata[SIZE_W-1:0]);
         end
         if (req_tvalid && req_tready) begin
            tracker.note_request(req_tdata[0]);
         end
         if (rsp_tvalid && rsp_tready) begin
            tracker.check_entry(rsp_tdata[3:0], rsp_tdata[8:4], rsp_tlast, rsp_tuser);
         end
      end
   end

   // A hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("next_lexicographic_permutation_top verification failed");
         $finish;
      end
   end

   // Offers one request and returns at the edge where it is taken. The valid stays high so
   // that a following request goes out back to back unless the next call idles first.
   task automatic send_request(logic restart);
      while (!quiet_run && $urandom_range(0, 99) < 7) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'b0, restart};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   // Lowers the request valid, waits for every owed entry, then lets the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the size register through a setup and an access cycle. The block must be idle.
   // Bits above the register width carry random noise, which the block must ignore.
   task automatic write_size(logic [SIZE_W-1:0] value);
      drain();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= SIZE_ADDR;
      csr_pwdata <= ($urandom() & ~32'h1F) | 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      size_writes++;
   endtask

   task automatic send_advances(int count);
      for (int i = 0; i < count; i++) begin
         send_request(ADVANCE);
      end
   endtask

   // Picks a size for a random phase: mostly small ones so that wraps come often, a few
   // full-size runs, and some values outside the legal range that must clamp.
   function automatic logic [SIZE_W-1:0] pick_size();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick <= 5) return SIZE_W'($urandom_range(2, 4));
      if (pick == 6) return SIZE_W'($urandom_range(5, 8));
      if (pick == 7) return SIZE_W'(MAX_CITIES);
      if (pick == 8) return SIZE_W'($urandom_range(0, 1));
      return SIZE_W'($urandom_range(17, 31));
   endfunction

   initial begin
      int phase;
      int phase_items;
      int sent;
      logic [SIZE_W-1:0] size_value;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. The reset size of sixteen is used first, straight out of reset.
      send_advances(2);
      send_request(RESTART);
      send_request(ADVANCE);

      // Two cities: the second advance leaves the descending order and must wrap.
      write_size(5'd2);
      send_advances(3);
      send_request(RESTART);

      // Three cities: five advances reach the descending order, the sixth wraps.
      write_size(5'd3);
      send_advances(6);

      // Sizes below two act as two; the first advance gives the descending order.
      write_size(5'd0);
      send_advances(2);
      write_size(5'd1);
      send_request(ADVANCE);

      // Sizes above the store depth act as the full depth.
      write_size(5'd31);
      send_request(ADVANCE);
      send_request(RESTART);
      write_size(5'd17);
      send_request(ADVANCE);

      // Random part: phases of one size each, mostly advances with an occasional restart.
      // One phase runs without any idling on either side.
      sent = 0;
      phase = 0;
      while (sent < RANDOM_REQUESTS) begin
         size_value = pick_size();
         write_size(size_value);
         quiet_run = (phase == 2);
         phase_items = (tracker.city_count() > 8) ? $urandom_range(6, 14)
                                                  : $urandom_range(20, 50);
         for (int i = 0; i < phase_items; i++) begin
            send_request(($urandom_range(0, 9) == 0) ? RESTART : ADVANCE);
         end
         sent += phase_items;
         phase++;
      end
      quiet_run = 1'b0;
      drain();

      if (tracker.pending() != 0) begin
         tracker.failures++;
         $error("%0d entries never arrived", tracker.pending());
      end
      $display("Covered %0d requests over %0d size writes: %0d entries checked, %0d wraps.",
               tracker.requests, size_writes, tracker.entries, tracker.wraps);
      if (tracker.failures == 0) begin
         $display("next_lexicographic_permutation_top verification clean");
      end else begin
         $display("next_lexicographic_permutation_top verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/nlp_pkg.sv
rtl/nlp_ram.sv
rtl/nlp_ctrl.sv
rtl/nlp_dp.sv
rtl/next_lexicographic_permutation_top.sv
test/testbench.sv
